### src/mcc_pkg.sv
// shared types, constants and lookup functions for the config chain
`default_nettype none
package mcc_pkg;

    localparam int SLOTS = 6;
    localparam int WORD_W = 20;
    localparam int ID_W = 8;
    localparam int ID_ENTRIES = 12;

    typedef logic [1:0] count_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ID_W-1:0] id_t;
    typedef logic [1:0] req_code_t;

    localparam req_code_t REQ_CONFIGURE = 2'd0;
    localparam req_code_t REQ_UNCONFIGURE = 2'd1;
    localparam req_code_t REQ_IDENTIFY = 2'd2;
    localparam req_code_t REQ_RESET = 2'd3;

    typedef struct packed {
        req_code_t req_type;
        word_t bus_value;
    } req_t;

    localparam count_t COUNT_TABLE_A [SLOTS] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0};
    localparam count_t COUNT_TABLE_B [SLOTS] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0};

    localparam id_t ID_TABLE [ID_ENTRIES] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'hf6,
        8'h07, 8'hf8, 8'h01, 8'hf2, 8'h00, 8'h00
    };

    // table byte for slot and its pending count; out-of-range index reads zero
    function automatic id_t id_lookup(logic [2:0] slot, count_t count);
        logic [4:0] idx;
        idx = {1'b0, slot, 1'b0} + 5'd2 - {3'b000, count};
        if (idx > 5'(ID_ENTRIES - 1))
            return '0;
        return ID_TABLE[idx[3:0]];
    endfunction

    function automatic count_t reload_count(logic sel, logic [2:0] slot);
        return sel ? COUNT_TABLE_B[slot] : COUNT_TABLE_A[slot];
    endfunction

endpackage
`default_nettype wire

### src/mcc_ifs.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none
interface mcc_req_if;
    logic valid;
    logic ready;
    logic [1:0] req_type;
    logic [19:0] bus_value;
    modport source (output valid, output req_type, output bus_value, input ready);
    modport sink (input valid, input req_type, input bus_value, output ready);
endinterface

interface mcc_rsp_if;
    logic valid;
    logic ready;
    logic [7:0] id_value;
    modport source (output valid, output id_value, input ready);
    modport sink (input valid, input id_value, output ready);
endinterface
`default_nettype wire

### src/mcc_slot_bank.sv
// six slot registers with first-match search and per-request update
`default_nettype none
module mcc_slot_bank
    import mcc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic go,
    input wire req_t req,
    input wire logic model_select,
    output id_t id
);

    count_t count_reg [SLOTS];
    count_t count_next [SLOTS];
    word_t word0_reg [SLOTS];
    word_t word0_next [SLOTS];
    word_t word1_reg [SLOTS];
    word_t word1_next [SLOTS];

    always_comb
    begin
        logic found;
        count_t c;
        found = 1'b0;
        c = '0;
        id = '0;
        count_next = count_reg;
        word0_next = word0_reg;
        word1_next = word1_reg;
        unique case (req.req_type)
            REQ_CONFIGURE:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!found && count_reg[s] != 2'd0)
                    begin
                        found = 1'b1;
                        c = count_reg[s] - 2'd1;
                        count_next[s] = c;
                        if (c[0])
                            word1_next[s] = req.bus_value;
                        else
                            word0_next[s] = req.bus_value;
                    end
                end
            end
            REQ_UNCONFIGURE:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!found && word0_reg[s] == req.bus_value)
                    begin
                        found = 1'b1;
                        count_next[s] = reload_count(model_select, 3'(s));
                        word0_next[s] = '0;
                        word1_next[s] = '0;
                    end
                end
            end
            REQ_IDENTIFY:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!found && count_reg[s] != 2'd0)
                    begin
                        found = 1'b1;
                        id = id_lookup(3'(s), count_reg[s]);
                    end
                end
            end
            REQ_RESET:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    count_next[s] = reload_count(model_select, 3'(s));
                    word0_next[s] = '0;
                    word1_next[s] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                count_reg[s] <= COUNT_TABLE_A[s];
                word0_reg[s] <= '0;
                word1_reg[s] <= '0;
            end
        end
        else if (go)
        begin
            count_reg <= count_next;
            word0_reg <= word0_next;
            word1_reg <= word1_next;
        end
    end

endmodule
`default_nettype wire

### src/memory_controller_config_chain.sv
// top level: request register, slot bank and response register
//
//  channel  dir  payload                   transfer
//  req      in   req_type[1:0], bus_value  req.valid & req.ready
//  rsp      out  id_value[7:0]             rsp.valid & rsp.ready
//  cfg      in   cfg_wdata (model_select)  cfg_we
//
// one request per cycle while the response is not stalled; a request passes from
// the request register through the slot bank into the response register
// reset loads counts 1,2,2,2,2,0, clears all words and model_select
// a stalled response holds the request register; a new request is taken
// in the cycle the held one moves on
`default_nettype none
module memory_controller_config_chain
    import mcc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    mcc_req_if.sink req,
    mcc_rsp_if.source rsp,
    input wire logic cfg_we,
    input wire logic cfg_wdata
);

    logic model_select_reg;
    logic in_valid_reg;
    req_t in_reg;
    logic rsp_valid_reg;
    id_t rsp_id_reg;
    id_t id;
    logic advance;

    assign advance = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.id_value = rsp_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            model_select_reg <= 1'b0;
        else if (cfg_we)
            model_select_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
            rsp_id_reg <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_reg.req_type <= req.req_type;
                in_reg.bus_value <= req.bus_value;
            end
            if (advance)
                rsp_id_reg <= id;
        end
    end

    mcc_slot_bank u_slot_bank (
        .clk (clk),
        .rst_n (rst_n),
        .go (advance),
        .req (in_reg),
        .model_select (model_select_reg),
        .id (id)
    );

endmodule
`default_nettype wire
